FILE: hdl/bss_pkg.sv
// types and constants shared by the bounded sequence store
`default_nettype none
package bss_pkg;

    localparam int DW = 32;
    localparam int IW = 9;
    localparam int FW = 9;
    localparam int SW = 40;

    // element memory entries; fill and count are FW bits wide to match
    localparam int DEPTH = 256;

    localparam logic [FW-1:0] CAP_RESET = 9'd256;
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [3:0] {
        CMD_APPEND  = 4'd0,
        CMD_DELETE  = 4'd1,
        CMD_GET     = 4'd2,
        CMD_SET     = 4'd3,
        CMD_CLEAR   = 4'd4,
        CMD_ORDERED = 4'd5,
        CMD_PARITY  = 4'd6,
        CMD_MULT    = 4'd7,
        CMD_MINMAX  = 4'd8,
        CMD_PALIN   = 4'd9,
        CMD_SUM     = 4'd10
    } t_cmd_code;

    typedef enum logic [3:0] {
        OP_APPEND,
        OP_DELETE,
        OP_GET,
        OP_SET,
        OP_CLEAR,
        OP_ORDERED,
        OP_PARITY,
        OP_MULT,
        OP_MINMAX,
        OP_PALIN,
        OP_SUM,
        OP_NOP
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_INDEX = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FULL      = 3'd4,
        ST_ZERO_DIV  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DIV,
        S_DONE
    } t_bstate;

    typedef struct packed {
        t_op                   op;
        logic signed [IW-1:0]  index;
        logic signed [DW-1:0]  value;
    } t_item;

    typedef struct packed {
        t_status               status;
        logic signed [DW-1:0]  first;
        logic signed [DW-1:0]  second;
        logic signed [SW-1:0]  total;
        logic [FW-1:0]         count;
    } t_result;

endpackage
`default_nettype wire

FILE: hdl/bss_if.sv
// item channels of the bounded sequence store
`default_nettype none
interface bss_in_if;
    import bss_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [3:0]           command;
    logic signed [IW-1:0] index;
    logic signed [DW-1:0] value;

    modport source (output valid, command, index, value, input ready);
    modport sink (input valid, command, index, value, output ready);
endinterface

interface bss_out_if;
    import bss_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [2:0]           status;
    logic signed [DW-1:0] first_result;
    logic signed [DW-1:0] second_result;
    logic signed [SW-1:0] total;
    logic [FW-1:0]        count;

    modport source (output valid, status, first_result, second_result, total, count,
                    input ready);
    modport sink (input valid, status, first_result, second_result, total, count,
                  output ready);
endinterface
`default_nettype wire

FILE: hdl/bounded_sequence_store.sv
// Bounded sequence store: a list of signed 32-bit elements with update commands and queries.
// Items come in on i_in (command, index, value) and each yields exactly one result on o_out
// (status, first_result, second_result, total, count), in order, valid/ready handshake.
// A front end decodes items into a two-entry queue; the back end executes one command
// at a time against a DEPTH x 32 element memory with registered reads.
// Append, set, clear, unknown commands and early errors go from S_IDLE straight to S_DONE
// and the output register; get also passes through S_READ and S_EXEC. Scanning commands
// (delete, ordered, parity, minmax, sum) pass S_READ and S_EXEC once per element visited,
// palindrome once per element pair; multiples also wait on the bit-serial remainder unit.
// The capacity register (APB, address 0) limits appends; it resets to 256.
// Reset empties the list; memory contents are not cleared and need no clearing pass.
// When the receiver stalls, the finished result waits in the output register while
// the back end holds its next result; the queue still takes up to two more items.
`default_nettype none
module bounded_sequence_store
    import bss_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    bss_in_if.sink           i_in,
    bss_out_if.source        o_out,
    input  wire              psel,
    input  wire              penable,
    input  wire              pwrite,
    input  wire [2:0]        paddr,
    input  wire [31:0]       pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [FW-1:0] r_cap;
    logic          push;
    logic          full;
    logic          pop;
    logic          q_valid;
    t_item         f_item;
    t_item         q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_CAPACITY) begin
            r_cap <= pwdata[FW-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? {23'b0, r_cap} : 32'b0;

    bss_front u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_item (f_item)
    );

    bss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_item)
    );

    bss_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_capacity (r_cap),
        .i_q_valid  (q_valid),
        .i_q_item   (q_item),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule
`default_nettype wire

FILE: hdl/bss_front.sv
// front end: accepts items and decodes the command
`default_nettype none
module bss_front
    import bss_pkg::*;
(
    bss_in_if.sink  i_in,
    input  wire     i_full,
    output logic    o_push,
    output t_item   o_item
);

    t_op op;

    always_comb begin
        unique case (i_in.command)
            CMD_APPEND:  op = OP_APPEND;
            CMD_DELETE:  op = OP_DELETE;
            CMD_GET:     op = OP_GET;
            CMD_SET:     op = OP_SET;
            CMD_CLEAR:   op = OP_CLEAR;
            CMD_ORDERED: op = OP_ORDERED;
            CMD_PARITY:  op = OP_PARITY;
            CMD_MULT:    op = OP_MULT;
            CMD_MINMAX:  op = OP_MINMAX;
            CMD_PALIN:   op = OP_PALIN;
            CMD_SUM:     op = OP_SUM;
            default:     op = OP_NOP;
        endcase
    end

    assign i_in.ready   = !i_full;
    assign o_push       = i_in.valid && !i_full;
    assign o_item.op    = op;
    assign o_item.index = i_in.index;
    assign o_item.value = i_in.value;

endmodule
`default_nettype wire

FILE: hdl/bss_queue.sv
// two-entry queue of decoded items between front and back
`default_nettype none
module bss_queue
    import bss_pkg::*;
(
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_push,
    input  t_item  i_data,
    output logic   o_full,
    input  wire    i_pop,
    output logic   o_valid,
    output t_item  o_data
);

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

endmodule
`default_nettype wire

FILE: hdl/bss_remu.sv
// iterative unsigned remainder, one quotient bit per cycle
`default_nettype none
module bss_remu
    import bss_pkg::*;
(
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_start,
    input  wire [DW-1:0]   i_dividend,
    input  wire [DW-1:0]   i_divisor,
    output logic           o_done,
    output logic           o_zero
);

    localparam int CW = $clog2(DW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_num;
    logic [DW-1:0] r_den;
    logic [DW:0]   r_rem;
    logic [DW:0]   shifted;
    logic [DW:0]   n_rem;

    always_comb begin
        shifted = {r_rem[DW-1:0], r_num[DW-1]};
        if (shifted >= {1'b0, r_den}) begin
            n_rem = shifted - {1'b0, r_den};
        end else begin
            n_rem = shifted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DW-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_zero = (r_rem == '0);

endmodule
`default_nettype wire

FILE: hdl/bss_back.sv
// back end: element memory, command sequencer and result register
`default_nettype none
module bss_back
    import bss_pkg::*;
(
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire [FW-1:0]    i_capacity,
    input  wire             i_q_valid,
    input  t_item           i_q_item,
    output logic            o_pop,
    bss_out_if.source       o_out
);

    localparam int AW = $clog2(DEPTH);

    logic signed [DW-1:0] r_mem [DEPTH];
    logic signed [DW-1:0] r_qa;
    logic signed [DW-1:0] r_qb;

    t_bstate              r_state, n_state;
    logic [FW-1:0]        r_fill, n_fill;
    logic [FW-1:0]        r_i, n_i;
    logic [FW-1:0]        r_w, n_w;
    logic                 r_flag, n_flag;
    logic signed [DW-1:0] r_lo, n_lo;
    logic signed [DW-1:0] r_hi, n_hi;
    logic signed [SW-1:0] r_sum, n_sum;
    logic [FW-1:0]        r_mcnt, n_mcnt;
    t_item                r_item, n_item;
    t_result              r_res, n_res;
    logic                 r_ov, n_ov;
    t_result              r_out, n_out;

    logic                 we;
    logic [FW-1:0]        waddr;
    logic signed [DW-1:0] wdata;
    logic [FW-1:0]        ra;
    logic [FW-1:0]        rb;
    logic                 rem_start;
    logic                 rem_done;
    logic                 rem_zero;
    logic [DW-1:0]        mag_a;
    logic [DW-1:0]        mag_d;

    logic [FW-1:0]        limit;
    logic signed [FW:0]   sidx;
    logic signed [FW:0]   sfill;
    logic                 bad_idx;
    logic [FW-1:0]        pos;
    logic                 last;
    logic                 last_pair;
    logic                 last_half;
    logic                 fl;
    logic [FW-1:0]        nw;
    logic signed [DW-1:0] lo;
    logic signed [DW-1:0] hi;
    logic signed [SW-1:0] s;
    logic [FW-1:0]        mc;

    assign limit = (32'(i_capacity) > 32'(DEPTH)) ? FW'(DEPTH) : i_capacity;

    assign sidx    = {i_q_item.index[IW-1], i_q_item.index};
    assign sfill   = {1'b0, r_fill};
    assign bad_idx = (sidx >= sfill) || (sidx < -sfill);
    assign pos     = i_q_item.index[IW-1] ? (r_fill + FW'(i_q_item.index))
                                          : FW'(i_q_item.index);

    assign last      = (r_i == r_fill - 1'b1);
    assign last_pair = ({1'b0, r_i} + 10'd2 >= {1'b0, r_fill});
    assign last_half = (r_i + 1'b1 == (r_fill >> 1));

    assign ra = r_i;
    assign rb = (r_item.op == OP_PALIN) ? (r_fill - 1'b1 - r_i) : (r_i + 1'b1);

    assign mag_a = r_qa[DW-1] ? DW'(-r_qa) : DW'(r_qa);
    assign mag_d = r_item.value[DW-1] ? DW'(-r_item.value) : DW'(r_item.value);

    bss_remu u_remu (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (mag_a),
        .i_divisor  (mag_d),
        .o_done     (rem_done),
        .o_zero     (rem_zero)
    );

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[AW'(waddr)] <= wdata;
        end
        r_qa <= r_mem[AW'(ra)];
        r_qb <= r_mem[AW'(rb)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_w    <= n_w;
        r_flag <= n_flag;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_sum  <= n_sum;
        r_mcnt <= n_mcnt;
        r_item <= n_item;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_i       = r_i;
        n_w       = r_w;
        n_flag    = r_flag;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_sum     = r_sum;
        n_mcnt    = r_mcnt;
        n_item    = r_item;
        n_res     = r_res;
        n_ov      = r_ov;
        n_out     = r_out;
        o_pop     = 1'b0;
        we        = 1'b0;
        waddr     = '0;
        wdata     = '0;
        rem_start = 1'b0;
        fl        = 1'b0;
        nw        = r_w;
        lo        = r_lo;
        hi        = r_hi;
        s         = r_sum;
        mc        = r_mcnt;

        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_item  = i_q_item;
                    n_res   = '0;
                    n_i     = '0;
                    n_w     = '0;
                    n_flag  = 1'b1;
                    n_sum   = '0;
                    n_mcnt  = '0;
                    n_state = S_DONE;
                    case (i_q_item.op)
                        OP_APPEND: begin
                            if (r_fill >= limit) begin
                                n_res.status = ST_FULL;
                            end else begin
                                we     = 1'b1;
                                waddr  = r_fill;
                                wdata  = i_q_item.value;
                                n_fill = r_fill + 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_fill = '0;
                        end
                        OP_GET, OP_SET: begin
                            if (bad_idx) begin
                                n_res.status = ST_BAD_INDEX;
                            end else if (i_q_item.op == OP_SET) begin
                                we    = 1'b1;
                                waddr = pos;
                                wdata = i_q_item.value;
                            end else begin
                                n_i     = pos;
                                n_state = S_READ;
                            end
                        end
                        OP_DELETE, OP_ORDERED, OP_PARITY, OP_MULT, OP_MINMAX,
                        OP_PALIN, OP_SUM: begin
                            if (r_fill == '0) begin
                                n_res.status = ST_EMPTY;
                            end else if (i_q_item.op == OP_MULT && i_q_item.value == '0) begin
                                n_res.status = ST_ZERO_DIV;
                            end else if ((i_q_item.op == OP_ORDERED || i_q_item.op == OP_PARITY
                                          || i_q_item.op == OP_PALIN) && r_fill == FW'(1)) begin
                                n_res.first = DW'(1);
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_READ;
                n_i     = r_i + 1'b1;
                case (r_item.op)
                    OP_GET: begin
                        n_res.first = r_qa;
                        n_state     = S_DONE;
                    end
                    OP_DELETE: begin
                        // survivors are packed down behind the read pointer
                        if (r_qa != r_item.value) begin
                            we    = 1'b1;
                            waddr = r_w;
                            wdata = r_qa;
                            nw    = r_w + 1'b1;
                        end
                        n_w = nw;
                        if (last) begin
                            n_res.status = (nw == r_fill) ? ST_NOT_FOUND : ST_OK;
                            n_fill       = nw;
                            n_state      = S_DONE;
                        end
                    end
                    OP_ORDERED, OP_PARITY, OP_PALIN: begin
                        if (r_item.op == OP_ORDERED) begin
                            fl = r_flag && !(r_qa > r_qb);
                        end else if (r_item.op == OP_PARITY) begin
                            fl = r_flag && (r_qa[0] ^ r_qb[0]);
                        end else begin
                            fl = r_flag && (r_qa == r_qb);
                        end
                        n_flag = fl;
                        if ((r_item.op == OP_PALIN) ? last_half : last_pair) begin
                            n_res.first = DW'(fl);
                            n_state     = S_DONE;
                        end
                    end
                    OP_MINMAX: begin
                        lo   = (r_i == '0 || r_qa < r_lo) ? r_qa : r_lo;
                        hi   = (r_i == '0 || r_qa > r_hi) ? r_qa : r_hi;
                        n_lo = lo;
                        n_hi = hi;
                        if (last) begin
                            n_res.first  = lo;
                            n_res.second = hi;
                            n_state      = S_DONE;
                        end
                    end
                    OP_SUM: begin
                        s     = r_sum + SW'(r_qa);
                        n_sum = s;
                        if (last) begin
                            n_res.total = s;
                            n_state     = S_DONE;
                        end
                    end
                    OP_MULT: begin
                        rem_start = 1'b1;
                        n_i       = r_i;
                        n_state   = S_DIV;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_DIV: begin
                if (rem_done) begin
                    mc     = r_mcnt + FW'(rem_zero);
                    n_mcnt = mc;
                    if (last) begin
                        n_res.first = DW'(mc);
                        n_state     = S_DONE;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            S_DONE: begin
                if (!r_ov || o_out.ready) begin
                    n_ov        = 1'b1;
                    n_out       = r_res;
                    n_out.count = r_fill;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out.valid         = r_ov;
    assign o_out.status        = r_out.status;
    assign o_out.first_result  = r_out.first;
    assign o_out.second_result = r_out.second;
    assign o_out.total         = r_out.total;
    assign o_out.count         = r_out.count;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= 32'(DEPTH))
        else $error("fill beyond memory depth");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.status != ST_OK) |->
            (r_out.first == '0 && r_out.second == '0 && r_out.total == '0))
        else $error("failed command carries nonzero data");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.status == ST_EMPTY) |-> (r_out.count == '0))
        else $error("empty status with elements held");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_item.op == OP_MULT) |=> (r_state == S_DIV))
        else $error("remainder unit started without waiting");

endmodule
`default_nettype wire
